@@ hdl/ssd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types and constants of the SCAN disk scheduler: word formats,
// cell chain link, cell operations, sequencer states, register indexes.
// ----------------------------------------------------------------------------
package ssd_pkg;

	localparam int MAX_REQUESTS = 32;
	localparam int NUM_CELLS    = MAX_REQUESTS;
	localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
	localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

	localparam int TRACK_W      = 16;
	localparam int TRACKS_W     = 17;
	localparam int MOVE_W       = 22;

	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 17;

	localparam logic [CFG_IDX_W-1:0] REG_START_HEAD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISK_TRACKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_UP    = 2'd2;

	typedef struct packed {
		logic [TRACK_W-1:0] track;
		logic               batch_end;
	} in_word_t;

	typedef struct packed {
		logic [TRACK_W-1:0] seek_track;
		logic [MOVE_W-1:0]  total_movement;
		logic               sequence_end;
	} out_word_t;

	typedef struct packed {
		logic [TRACK_W-1:0] val;
		logic               valid;
		logic               keep;
	} cell_link_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INSERT,
		OP_SHL,
		OP_SHR
	} cell_op_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_HEAD,
		ST_DRAIN,
		ST_TOP,
		ST_POP
	} state_t;

endpackage

@@ hdl/ssd_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_cell
// One cell of a sorted chain: holds one track, takes part in a sorted
// insert, or shifts toward either neighbor.
// ----------------------------------------------------------------------------
module ssd_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ssd_pkg::cell_op_t         op,
	input  logic [ssd_pkg::TRACK_W-1:0] ins_val,
	input  ssd_pkg::cell_link_t       left,
	input  ssd_pkg::cell_link_t       right,
	output ssd_pkg::cell_link_t       self
);

	logic [ssd_pkg::TRACK_W-1:0] val_q, val_d;
	logic                        valid_q, valid_d;
	logic                        keep;

	assign keep = valid_q && (val_q <= ins_val);

	always_comb begin
		val_d   = val_q;
		valid_d = valid_q;
		unique case (op)
			ssd_pkg::OP_HOLD: begin
			end
			ssd_pkg::OP_INSERT: begin
				if (!keep) begin
					if (left.keep) begin
						val_d   = ins_val;
						valid_d = 1'b1;
					end else begin
						val_d   = left.val;
						valid_d = left.valid;
					end
				end
			end
			ssd_pkg::OP_SHL: begin
				val_d   = right.val;
				valid_d = right.valid;
			end
			ssd_pkg::OP_SHR: begin
				val_d   = left.val;
				valid_d = left.valid;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	assign self.val   = val_q;
	assign self.valid = valid_q;
	assign self.keep  = keep;

endmodule

@@ hdl/ssd_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_chain
// Row of cells. Inserts keep the row sorted ascending from cell 0; shifts
// move words toward cell 0 (out at cell 0) or toward the far end (in at
// cell 0, out at the last cell).
// ----------------------------------------------------------------------------
module ssd_chain (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ssd_pkg::cell_op_t           op,
	input  logic [ssd_pkg::TRACK_W-1:0] ins_val,
	input  logic                        ins_valid,
	output ssd_pkg::cell_link_t         first,
	output ssd_pkg::cell_link_t         last,
	output logic                        second_valid
);

	ssd_pkg::cell_link_t lnk [ssd_pkg::NUM_CELLS];
	ssd_pkg::cell_link_t edge_in;
	ssd_pkg::cell_link_t empty_link;

	assign edge_in.val      = ins_val;
	assign edge_in.valid    = ins_valid;
	assign edge_in.keep     = 1'b1;
	assign empty_link.val   = '0;
	assign empty_link.valid = 1'b0;
	assign empty_link.keep  = 1'b0;

	for (genvar i = 0; i < ssd_pkg::NUM_CELLS; i++) begin : g_cell
		ssd_pkg::cell_link_t left_l, right_l;
		if (i == 0) begin : g_l0
			assign left_l = edge_in;
		end else begin : g_ln
			assign left_l = lnk[i-1];
		end
		if (i == ssd_pkg::NUM_CELLS - 1) begin : g_rl
			assign right_l = empty_link;
		end else begin : g_rn
			assign right_l = lnk[i+1];
		end
		ssd_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.op      (op),
			.ins_val (ins_val),
			.left    (left_l),
			.right   (right_l),
			.self    (lnk[i])
		);
	end

	assign first = lnk[0];
	assign last  = lnk[ssd_pkg::NUM_CELLS-1];

	if (ssd_pkg::NUM_CELLS > 1) begin : g_sec
		assign second_valid = lnk[1].valid;
	end else begin : g_nosec
		assign second_valid = 1'b0;
	end

endmodule

@@ hdl/scan_disk_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_disk_scheduler
// SCAN seek scheduler: requests sort into a cell chain as they arrive, then
// the chain drains once through a stack chain to give the elevator order.
// ----------------------------------------------------------------------------
// Load: one request word per cycle (sorted insert in the cell chain).
// Schedule: head visit, drain of every sort cell, turn track, then one pop per
// request stacked for the return sweep; input is held meanwhile.
// The first result word is registered from the head state, which follows
// the accepted batch_end word; output stalls freeze the sequencer. Reset
// clears cell valid bits, state, count and output valid; config to defaults.
module scan_disk_scheduler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  ssd_pkg::in_word_t              in_word,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ssd_pkg::out_word_t             out_word,
	input  logic                           cfg_we,
	input  logic [ssd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ssd_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [ssd_pkg::TRACK_W-1:0]  start_head_q;
	logic [ssd_pkg::TRACKS_W-1:0] disk_tracks_q;
	logic                         sweep_up_q;

	ssd_pkg::state_t state_q, state_d;
	logic [ssd_pkg::CNT_W-1:0] count_q;
	logic [ssd_pkg::IDX_W-1:0] idx_q;
	logic [ssd_pkg::TRACK_W-1:0] pos_q;
	logic [ssd_pkg::MOVE_W-1:0]  moved_q;
	logic out_valid_q;
	ssd_pkg::out_word_t out_q;

	ssd_pkg::cell_op_t sort_op, stack_op;
	logic [ssd_pkg::TRACK_W-1:0] push_val;
	logic push_valid;
	ssd_pkg::cell_link_t sort_first, sort_last, stack_first;
	logic stack_second_valid;

	logic in_fire, has_room, out_free;
	logic emit, emit_end;
	logic [ssd_pkg::TRACK_W-1:0] emit_track, top_track, cur_pos, seek_dist;
	logic [ssd_pkg::MOVE_W-1:0]  cur_moved;
	ssd_pkg::cell_link_t drain_e;
	logic direct;
	logic drain_done;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_head_q  <= '0;
			disk_tracks_q <= ssd_pkg::TRACKS_W'(65536);
			sweep_up_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				ssd_pkg::REG_START_HEAD:  start_head_q  <= cfg_data[ssd_pkg::TRACK_W-1:0];
				ssd_pkg::REG_DISK_TRACKS: disk_tracks_q <= cfg_data[ssd_pkg::TRACKS_W-1:0];
				ssd_pkg::REG_SWEEP_UP:    sweep_up_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (disk_tracks_q == '0) begin
			top_track = '0;
		end else if (disk_tracks_q[ssd_pkg::TRACKS_W-1] &&
				(disk_tracks_q[ssd_pkg::TRACK_W-1:0] != '0)) begin
			top_track = '1;
		end else begin
			top_track = ssd_pkg::TRACK_W'(disk_tracks_q - ssd_pkg::TRACKS_W'(1));
		end
	end

	assign in_ready   = (state_q == ssd_pkg::ST_LOAD);
	assign in_fire    = in_valid && in_ready;
	assign has_room   = (count_q < ssd_pkg::CNT_W'(ssd_pkg::MAX_REQUESTS));
	assign out_free   = !out_valid_q || out_ready;
	assign drain_e    = sweep_up_q ? sort_first : sort_last;
	assign direct     = sweep_up_q ? (drain_e.val >= start_head_q)
	                               : (drain_e.val < start_head_q);
	assign drain_done = (idx_q == ssd_pkg::IDX_W'(ssd_pkg::MAX_REQUESTS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ssd_pkg::ST_LOAD: begin
				if (in_fire && in_word.batch_end) state_d = ssd_pkg::ST_HEAD;
			end
			ssd_pkg::ST_HEAD: begin
				if (out_free) state_d = ssd_pkg::ST_DRAIN;
			end
			ssd_pkg::ST_DRAIN: begin
				if (out_free && drain_done) state_d = ssd_pkg::ST_TOP;
			end
			ssd_pkg::ST_TOP: begin
				if (out_free) state_d = stack_first.valid ? ssd_pkg::ST_POP : ssd_pkg::ST_LOAD;
			end
			ssd_pkg::ST_POP: begin
				if (out_free && !stack_second_valid) state_d = ssd_pkg::ST_LOAD;
			end
			default: state_d = ssd_pkg::ST_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		sort_op    = ssd_pkg::OP_HOLD;
		stack_op   = ssd_pkg::OP_HOLD;
		push_val   = drain_e.val;
		push_valid = 1'b0;
		emit       = 1'b0;
		emit_end   = 1'b0;
		emit_track = start_head_q;
		unique case (state_q)
			ssd_pkg::ST_LOAD: begin
				if (in_fire && has_room) sort_op = ssd_pkg::OP_INSERT;
			end
			ssd_pkg::ST_HEAD: begin
				emit = out_free;
			end
			ssd_pkg::ST_DRAIN: begin
				if (out_free) begin
					sort_op = sweep_up_q ? ssd_pkg::OP_SHL : ssd_pkg::OP_SHR;
					if (drain_e.valid) begin
						if (direct) begin
							emit       = 1'b1;
							emit_track = drain_e.val;
						end else begin
							stack_op   = ssd_pkg::OP_SHR;
							push_valid = 1'b1;
						end
					end
				end
			end
			ssd_pkg::ST_TOP: begin
				emit       = out_free;
				emit_track = sweep_up_q ? top_track : '0;
				emit_end   = !stack_first.valid;
			end
			ssd_pkg::ST_POP: begin
				emit       = out_free;
				emit_track = stack_first.val;
				emit_end   = !stack_second_valid;
				if (out_free) stack_op = ssd_pkg::OP_SHL;
			end
			default: begin
			end
		endcase
	end

	ssd_chain u_sort (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (sort_op),
		.ins_val      (in_word.track),
		.ins_valid    (1'b0),
		.first        (sort_first),
		.last         (sort_last),
		.second_valid ()
	);

	ssd_chain u_stack (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (stack_op),
		.ins_val      (push_val),
		.ins_valid    (push_valid),
		.first        (stack_first),
		.last         (),
		.second_valid (stack_second_valid)
	);

	// running movement
	assign cur_pos   = (state_q == ssd_pkg::ST_HEAD) ? start_head_q : pos_q;
	assign cur_moved = (state_q == ssd_pkg::ST_HEAD) ? '0 : moved_q;
	assign seek_dist = (emit_track > cur_pos) ? (emit_track - cur_pos)
	                                          : (cur_pos - emit_track);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ssd_pkg::ST_LOAD;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				if (in_word.batch_end) count_q <= '0;
				else if (has_room) count_q <= count_q + ssd_pkg::CNT_W'(1);
			end
			if (state_q == ssd_pkg::ST_HEAD) idx_q <= '0;
			else if (state_q == ssd_pkg::ST_DRAIN && out_free) idx_q <= idx_q + ssd_pkg::IDX_W'(1);
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pos_q                <= emit_track;
			moved_q              <= cur_moved + ssd_pkg::MOVE_W'(seek_dist);
			out_q.seek_track     <= emit_track;
			out_q.total_movement <= cur_moved + ssd_pkg::MOVE_W'(seek_dist);
			out_q.sequence_end   <= emit_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

@@ hdl/ssd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_checker
// Port-level checks of the SCAN disk scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module ssd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input ssd_pkg::in_word_t              in_word,
	input logic                           out_valid,
	input logic                           out_ready,
	input ssd_pkg::out_word_t             out_word
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	a_busy_mid_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.sequence_end |-> !in_ready)
		else $error("input open in the middle of a seek sequence");

	a_move_grows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_word.sequence_end |=>
		!out_valid || (out_word.total_movement >= $past(out_word.total_movement)))
		else $error("running movement went down");

	a_load_stays: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_word.batch_end |=> in_ready)
		else $error("input closed after a request that is not last");

endmodule

bind scan_disk_scheduler ssd_checker u_ssd_checker (.*);
